[hdl/crcl_pkg.sv]
// Shared types and constants for the chunk range cache lookup unit.
package crcl_pkg;

    // Configuration port
    localparam int unsigned PADDR_W = 3;
    localparam logic REG_CHUNK_LENGTH = 1'b0;   // register index, taken from paddr[2]

    localparam logic [15:0] CHUNK_LENGTH_RESET = 16'd58315;
    localparam logic [31:0] STAMP_MAX = 32'hFFFF_FFFF;

    // Input word
    typedef struct packed {
        logic [31:0] start_offset;
        logic [19:0] range_size;
    } in_t;

    // Result word
    typedef struct packed {
        logic [31:0] chunk_index;
        logic [2:0]  cache_way;
        logic        hit;
        logic [15:0] copy_offset;
        logic [15:0] copy_length;
        logic        last;
        logic        too_wide;
    } out_t;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIV_FIRST,
        ST_DIV_LAST,
        ST_SCAN,
        ST_UPDATE,
        ST_WIDE
    } state_t;

endpackage

[hdl/crcl_div.sv]
// Restoring divider, one quotient bit per cycle, 32-bit dividend by 16-bit divisor.
module crcl_div
    import crcl_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [31:0] dividend,
    input  logic [15:0] divisor,
    output logic        busy,
    output logic        done,
    output logic [31:0] quotient,
    output logic [15:0] remainder
);

    logic        busy_reg;
    logic        done_reg;
    logic [4:0]  cnt_reg;
    logic [31:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] dvs_reg;

    logic [16:0] partial;
    logic [16:0] diff;
    logic        ge;
    logic [15:0] rem_next;
    logic [31:0] quo_next;

    // One restoring step: bring down the next dividend bit, subtract if it fits
    always_comb begin
        partial  = {rem_reg, quo_reg[31]};
        ge       = (partial >= {1'b0, dvs_reg});
        diff     = partial - {1'b0, dvs_reg};
        rem_next = ge ? diff[15:0] : partial[15:0];
        quo_next = {quo_reg[30:0], ge};
    end

    // Control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= 5'd31;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end else if (busy_reg) begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy      = busy_reg;
    assign done      = done_reg;
    assign quotient  = quo_reg;
    assign remainder = rem_reg;

endmodule

[hdl/chunk_range_cache_lookup_unit.sv]
// Top level: range split into chunks and LRU way lookup for each chunk.
// First come two 32-step divisions, then per chunk a scan of up to CACHE_WAYS ways
// and an update step that waits for a free output slot. The unit takes one word at
// a time, serialised on the shared divider and the single way comparator. A too-wide
// request gives its error word after the two divisions, with no way scan.
// Reset (aresetn, synchronous, active low) clears valid bits, stamps and counter; length returns to 58315.
module chunk_range_cache_lookup_unit
    import crcl_pkg::*;
#(
    parameter int CACHE_WAYS = 8,
    parameter int MAX_SPAN   = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input channel
    input  logic               s_valid,
    output logic               s_ready,
    input  in_t                s_data,
    // result channel
    output logic               m_valid,
    input  logic               m_ready,
    output out_t               m_data
);

    localparam int WAY_W  = (CACHE_WAYS > 1) ? $clog2(CACHE_WAYS) : 1;
    localparam int WEXT_W = (WAY_W > 3) ? WAY_W : 3;
    localparam int SPAN_W = $clog2(MAX_SPAN + 1);

    state_t state_reg, state_next;

    // configuration and request
    logic [15:0]       chunk_len_reg;
    logic [15:0]       clen_reg;
    logic [19:0]       size_reg;
    logic [31:0]       first_idx_reg;
    logic [15:0]       first_off_reg;
    logic [15:0]       last_off_reg;

    // chunk loop
    logic [31:0]       cur_idx_reg;
    logic [SPAN_W-1:0] remain_reg;
    logic              is_first_reg;

    // way scan
    logic [WAY_W-1:0]  scan_idx_reg;
    logic [WAY_W-1:0]  target_reg;
    logic [31:0]       min_stamp_reg;
    logic              found_reg;

    // cache state
    logic [CACHE_WAYS-1:0] way_valid_reg;
    logic [31:0]           way_tag_reg   [CACHE_WAYS];
    logic [31:0]           way_stamp_reg [CACHE_WAYS];
    logic [31:0]           use_ctr_reg;

    // output stage
    logic              m_valid_reg;
    out_t              out_reg;
    out_t              out_next;

    // divider
    logic              div_start;
    logic [31:0]       div_dividend;
    logic [15:0]       clen_eff;
    logic [15:0]       div_divisor;
    logic              div_busy;
    logic              div_done;
    logic [31:0]       div_quo;
    logic [15:0]       div_rem;

    // control decodes
    logic              accept;
    logic              cfg_wr;
    logic              slot_free;
    logic              way_hit;
    logic              way_older;
    logic              scan_end;
    logic              too_wide;
    logic              do_update;
    logic              do_wide;
    logic              last_chunk;
    logic [WEXT_W-1:0] target_ext;

    // APB register
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = (paddr[2] == REG_CHUNK_LENGTH) ? {16'd0, chunk_len_reg} : 32'd0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chunk_len_reg <= CHUNK_LENGTH_RESET;
        end else if (cfg_wr && paddr[2] == REG_CHUNK_LENGTH) begin
            chunk_len_reg <= pwdata[15:0];
        end
    end

    // zero length acts as one; the first division latches the live length
    assign clen_eff    = (chunk_len_reg == 16'd0) ? 16'd1 : chunk_len_reg;
    assign div_divisor = (state_reg == ST_IDLE) ? clen_eff : clen_reg;

    // shared divider
    crcl_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (div_start),
        .dividend  (div_dividend),
        .divisor   (div_divisor),
        .busy      (div_busy),
        .done      (div_done),
        .quotient  (div_quo),
        .remainder (div_rem)
    );

    // per-way compare for the way under the scan pointer
    assign way_hit   = way_valid_reg[scan_idx_reg] && (way_tag_reg[scan_idx_reg] == cur_idx_reg);
    assign way_older = way_stamp_reg[scan_idx_reg] < min_stamp_reg;
    assign scan_end  = (scan_idx_reg == WAY_W'(CACHE_WAYS - 1));
    assign too_wide  = (div_quo >= 32'(MAX_SPAN));
    assign slot_free = !m_valid_reg || m_ready;
    assign last_chunk = (remain_reg == '0);

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_DIV_FIRST;
            end
            ST_DIV_FIRST: begin
                if (div_done) state_next = ST_DIV_LAST;
            end
            ST_DIV_LAST: begin
                if (div_done) state_next = too_wide ? ST_WIDE : ST_SCAN;
            end
            ST_SCAN: begin
                if (way_hit || scan_end) state_next = ST_UPDATE;
            end
            ST_UPDATE: begin
                if (slot_free) state_next = last_chunk ? ST_IDLE : ST_SCAN;
            end
            ST_WIDE: begin
                if (slot_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        s_ready      = 1'b0;
        div_start    = 1'b0;
        div_dividend = s_data.start_offset;
        do_update    = 1'b0;
        do_wide      = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready   = 1'b1;
                div_start = s_valid;
            end
            ST_DIV_FIRST: begin
                div_start    = div_done;
                div_dividend = 32'({4'd0, div_rem} + {1'b0, size_reg});
            end
            ST_UPDATE: begin
                do_update = slot_free;
            end
            ST_WIDE: begin
                do_wide = slot_free;
            end
            default: ;
        endcase
    end

    assign accept = s_valid && s_ready;

    // result word for the current chunk, or the error word
    assign target_ext = WEXT_W'(target_reg);
    always_comb begin
        out_next = '0;
        if (state_reg == ST_WIDE) begin
            out_next.last     = 1'b1;
            out_next.too_wide = 1'b1;
        end else begin
            out_next.chunk_index = cur_idx_reg;
            out_next.cache_way   = target_ext[2:0];
            out_next.hit         = found_reg;
            out_next.last        = last_chunk;
            if (is_first_reg) begin
                out_next.copy_offset = first_off_reg;
                out_next.copy_length = last_chunk ? (last_off_reg - first_off_reg)
                                                  : (clen_reg - first_off_reg);
            end else if (last_chunk) begin
                out_next.copy_length = last_off_reg;
            end else begin
                out_next.copy_length = clen_reg;
            end
        end
    end

    // sequencer and loop registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            clen_reg <= clen_eff;
            size_reg <= s_data.range_size;
        end
        if (state_reg == ST_DIV_FIRST && div_done) begin
            first_idx_reg <= div_quo;
            first_off_reg <= div_rem;
        end
        if (state_reg == ST_DIV_LAST && div_done) begin
            last_off_reg <= div_rem;
            remain_reg   <= div_quo[SPAN_W-1:0];
            cur_idx_reg  <= first_idx_reg;
            is_first_reg <= 1'b1;
        end
        if (do_update && !last_chunk) begin
            cur_idx_reg  <= cur_idx_reg + 32'd1;
            remain_reg   <= remain_reg - SPAN_W'(1);
            is_first_reg <= 1'b0;
        end
        // way scan: stop on a hit, else track the first oldest stamp
        if ((state_reg == ST_DIV_LAST && div_done) || do_update) begin
            scan_idx_reg  <= '0;
            target_reg    <= '0;
            min_stamp_reg <= STAMP_MAX;
            found_reg     <= 1'b0;
        end else if (state_reg == ST_SCAN) begin
            if (way_hit) begin
                found_reg  <= 1'b1;
                target_reg <= scan_idx_reg;
            end else begin
                if (way_older) begin
                    min_stamp_reg <= way_stamp_reg[scan_idx_reg];
                    target_reg    <= scan_idx_reg;
                end
                if (!scan_end) scan_idx_reg <= scan_idx_reg + WAY_W'(1);
            end
        end
    end

    // cache state with reset values
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            way_valid_reg <= '0;
            use_ctr_reg   <= '0;
            for (int i = 0; i < CACHE_WAYS; i++) begin
                way_stamp_reg[i] <= '0;
            end
        end else if (do_update) begin
            use_ctr_reg                <= use_ctr_reg + 32'd1;
            way_stamp_reg[target_reg]  <= use_ctr_reg + 32'd1;
            way_valid_reg[target_reg]  <= 1'b1;
        end
    end

    // tags have no reset; only read behind a valid bit
    always_ff @(posedge aclk) begin
        if (do_update && !found_reg) begin
            way_tag_reg[target_reg] <= cur_idx_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (do_update || do_wide) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_update || do_wide) begin
            out_reg <= out_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef SYNTHESIS
    // an error word always closes its request
    a_wide_is_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.too_wide |-> m_data.last)
        else $error("too_wide word without last");

    // each lookup advances the use counter by exactly one
    a_ctr_step: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update |=> use_ctr_reg == $past(use_ctr_reg) + 32'd1)
        else $error("use counter did not step");

    // a way once filled stays valid
    a_valid_sticky: assert property (@(posedge aclk) disable iff (!aresetn)
        1'b1 |=> (way_valid_reg & $past(way_valid_reg)) == $past(way_valid_reg))
        else $error("way valid bit dropped");

    // a hit always points at a valid way
    a_hit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UPDATE && found_reg |-> way_valid_reg[target_reg])
        else $error("hit on an invalid way");

    // copy offset lies inside the chunk
    a_off_range: assert property (@(posedge aclk) disable iff (!aresetn)
        do_update |=> out_reg.copy_offset < clen_reg)
        else $error("copy offset beyond chunk length");

    // the divider is only started when idle
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider started while busy");
`endif

endmodule
